>>> design/rdf_pkg.sv
`default_nettype none

package rdf_pkg;

	// build-time defaults for the top-level parameters
	localparam int FRAME_SLOTS = 128;
	localparam int FEAT_SIZE   = 13;

	// regression window shape, fixed at build time
	localparam int DELTA_ORDER  = 2;
	localparam int DELTA_WINDOW = 2;

	localparam int FRAME_W    = 7;
	localparam int ELEM_W     = 4;
	localparam int ELEM_IDX_W = 5;
	localparam int DATA_W     = 32;
	localparam int ORDER_W    = 2;
	localparam int ORD_IDX_W  = 1;
	localparam int ACC_W      = 48;
	localparam int COEF_W     = 10;
	localparam int OFF_W      = 5;
	localparam int MAX_TAPS   = 4 * DELTA_WINDOW + 1;
	localparam int TAP_W      = $clog2(MAX_TAPS);
	localparam int DIV_RADIX  = 4;
	localparam int DIV_STEPS  = DATA_W / DIV_RADIX;
	localparam int STEP_W     = $clog2(DIV_STEPS);

	localparam int NORM = DELTA_WINDOW * (DELTA_WINDOW + 1) * (2 * DELTA_WINDOW + 1) / 3;

	localparam logic OP_WRITE   = 1'b0;
	localparam logic OP_COMPUTE = 1'b1;

	typedef struct packed {
		logic                     op;
		logic [FRAME_W-1:0]       frame;
		logic [FRAME_W-1:0]       max_frame;
		logic [ELEM_W-1:0]        element;
		logic signed [DATA_W-1:0] value;
	} item_t;

	typedef struct packed {
		logic [ORDER_W-1:0]       order;
		logic [ELEM_W-1:0]        element_res;
		logic signed [DATA_W-1:0] delta_value;
		logic                     last;
	} result_t;

	// finished weighted sum handed from the MAC to the divider
	typedef struct packed {
		logic signed [ACC_W-1:0] acc;
		logic [ORD_IDX_W-1:0]    ord;
		logic [ELEM_IDX_W-1:0]   elem;
		logic                    last;
	} div_req_t;

	// numerator of the order-ord window at offset m (denominator NORM^ord)
	function automatic int win_num(int ord, int m);
		int s;
		int k;
		s = 0;
		if (ord == 1) begin
			if (m >= -DELTA_WINDOW && m <= DELTA_WINDOW) begin
				s = m;
			end
		end else begin
			for (int j = -DELTA_WINDOW; j <= DELTA_WINDOW; j++) begin
				k = m - j;
				if (k >= -DELTA_WINDOW && k <= DELTA_WINDOW) begin
					s = s + j * k;
				end
			end
		end
		return s;
	endfunction

	function automatic int tap_count(int ord);
		int n;
		n = 0;
		for (int m = -ord * DELTA_WINDOW; m <= ord * DELTA_WINDOW; m++) begin
			if (win_num(ord, m) != 0) begin
				n = n + 1;
			end
		end
		return n;
	endfunction

	// offset of the idx-th nonzero tap
	function automatic int tap_off(int ord, int idx);
		int n;
		int r;
		n = 0;
		r = 0;
		for (int m = -ord * DELTA_WINDOW; m <= ord * DELTA_WINDOW; m++) begin
			if (win_num(ord, m) != 0) begin
				if (n == idx) begin
					r = m;
				end
				n = n + 1;
			end
		end
		return r;
	endfunction

	function automatic longint den_of(int ord);
		longint d;
		d = (ord == 1) ? longint'(NORM) : longint'(NORM) * longint'(NORM);
		return d;
	endfunction

	// magnitude at or above this saturates (positive / negative result)
	function automatic longint thr_pos(int ord);
		longint d;
		d = den_of(ord);
		return (longint'(1) << 31) * d - d / 2;
	endfunction

	function automatic longint thr_neg(int ord);
		longint d;
		d = den_of(ord);
		return ((longint'(1) << 31) + 1) * d - d / 2;
	endfunction

	localparam int DEN_W = $clog2(den_of(DELTA_ORDER) + 1);

endpackage

`default_nettype wire

>>> design/regression_delta_features.sv
`default_nettype none

// Regression (delta) features of order 1..2 over a +-2 frame window, read from
// a store of static feature vectors. A write request (op 0) stores one static
// element (signed Q15.16) at frame slot, element; writes to an element past the
// vector length are dropped and produce no result. A compute request (op 1)
// names a centre frame and the last valid frame, and yields FEAT_SIZE results
// per order, order 1 first, elements ascending, with last set on the final one.
// Neighbor frames are clamped to 0..max_frame and then wrapped to the slot
// count. Each result is the exact window sum divided by the window norm (10 for
// order 1, 100 for order 2), rounded half away from zero and saturated to 32
// bits. An entry must be written before any compute request reads it.
// A write request leaves the input queue as it is written into the store. A
// compute request walks the tap list one store read per cycle through a single
// MAC (4 taps per element for order 1, 9 for order 2), then drains the MAC pipe
// per element; the rounding divider (4 quotient bits a cycle) runs alongside
// the next element. Both sides see 2-deep queues, so requests and results keep
// moving while the other side stalls. The feature store is one memory with a
// registered read port and no clearing pass.
module regression_delta_features #(
	parameter int FRAME_SLOTS = rdf_pkg::FRAME_SLOTS,
	parameter int FEAT_SIZE   = rdf_pkg::FEAT_SIZE
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	// request side
	input  wire logic             push,
	input  wire rdf_pkg::item_t   item,
	output logic                  full,
	// result side
	output logic                  empty,
	input  wire logic             pop,
	output rdf_pkg::result_t      result
);

	rdf_pkg::item_t    cmd;
	logic              cmd_empty;
	logic              cmd_pop;
	rdf_pkg::div_req_t div_req;
	logic              div_valid;
	logic              div_ready;
	rdf_pkg::result_t  div_res;
	logic              div_res_valid;
	logic              res_full;

	// front: take requests, drop bad writes, queue them
	rdf_front #(
		.FEAT_SIZE (FEAT_SIZE)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.item      (item),
		.full      (full),
		.cmd_pop   (cmd_pop),
		.cmd       (cmd),
		.cmd_empty (cmd_empty)
	);

	// back: feature store, tap sequencer and MAC
	rdf_back #(
		.FRAME_SLOTS (FRAME_SLOTS),
		.FEAT_SIZE   (FEAT_SIZE)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_empty (cmd_empty),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.div_req   (div_req),
		.div_valid (div_valid),
		.div_ready (div_ready)
	);

	// rounding, saturating divide by the window norm
	rdf_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (div_req),
		.req_valid (div_valid),
		.req_ready (div_ready),
		.res       (div_res),
		.res_valid (div_res_valid),
		.res_ready (!res_full)
	);

	// result queue toward the consumer
	rdf_fifo #(
		.T     (rdf_pkg::result_t),
		.DEPTH (2)
	) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (div_res_valid),
		.wdata  (div_res),
		.full   (res_full),
		.pop    (pop),
		.rdata  (result),
		.empty  (empty)
	);

endmodule

`default_nettype wire

>>> design/rdf_fifo.sv
`default_nettype none

module rdf_fifo #(
	parameter type T     = logic,
	parameter int  DEPTH = 2
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire T     wdata,
	output logic      full,
	input  wire logic pop,
	output T          rdata,
	output logic      empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	T                 slots_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0]   count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == (PTR_W+1)'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			slots_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + (PTR_W+1)'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - (PTR_W+1)'(1);
			end
		end
	end

endmodule

`default_nettype wire

>>> design/rdf_front.sv
`default_nettype none

module rdf_front #(
	parameter int FEAT_SIZE = rdf_pkg::FEAT_SIZE
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire rdf_pkg::item_t item,
	output logic                full,
	input  wire logic           cmd_pop,
	output rdf_pkg::item_t      cmd,
	output logic                cmd_empty
);

	logic accept;
	logic keep;

	// writes to an element past the vector are dropped here
	assign accept = push && !full;
	assign keep   = (item.op == rdf_pkg::OP_COMPUTE) || (int'(item.element) < FEAT_SIZE);

	rdf_fifo #(
		.T     (rdf_pkg::item_t),
		.DEPTH (2)
	) u_cmd_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (accept && keep),
		.wdata  (item),
		.full   (full),
		.pop    (cmd_pop),
		.rdata  (cmd),
		.empty  (cmd_empty)
	);

endmodule

`default_nettype wire

>>> design/rdf_back.sv
`default_nettype none

module rdf_back #(
	parameter int FRAME_SLOTS = rdf_pkg::FRAME_SLOTS,
	parameter int FEAT_SIZE   = rdf_pkg::FEAT_SIZE
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cmd_empty,
	input  wire rdf_pkg::item_t    cmd,
	output logic                   cmd_pop,
	output rdf_pkg::div_req_t      div_req,
	output logic                   div_valid,
	input  wire logic              div_ready
);

	localparam int SLOT_W    = $clog2(FRAME_SLOTS);
	localparam int DEPTH     = FRAME_SLOTS * FEAT_SIZE;
	localparam int ADDR_W    = $clog2(DEPTH);
	localparam int EIDX_W    = (FEAT_SIZE > 1) ? $clog2(FEAT_SIZE) : 1;
	localparam int FRAME_CNT = 1 << rdf_pkg::FRAME_W;
	localparam int FW        = rdf_pkg::FRAME_W;
	localparam int PROD_W    = rdf_pkg::DATA_W + rdf_pkg::COEF_W;

	typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_WAIT} state_t;

	logic [SLOT_W-1:0]                slot_tab [FRAME_CNT];
	logic signed [rdf_pkg::OFF_W-1:0] off_tab  [rdf_pkg::DELTA_ORDER][rdf_pkg::MAX_TAPS];
	logic signed [rdf_pkg::COEF_W-1:0] coef_tab [rdf_pkg::DELTA_ORDER][rdf_pkg::MAX_TAPS];
	logic [rdf_pkg::TAP_W-1:0]        tap_last [rdf_pkg::DELTA_ORDER];

	logic [rdf_pkg::DATA_W-1:0] store_mem [DEPTH];

	state_t                         state_q;
	logic [rdf_pkg::ORD_IDX_W-1:0]  ord_q;
	logic [EIDX_W-1:0]              elem_q;
	logic [rdf_pkg::TAP_W-1:0]      tap_q;
	logic [FW-1:0]                  frame_q;
	logic [FW-1:0]                  maxf_q;

	logic                               valid_s1, first_s1, last_s1;
	logic signed [rdf_pkg::DATA_W-1:0]  rdata_s1;
	logic signed [rdf_pkg::COEF_W-1:0]  coef_s1;
	logic                               valid_s2, first_s2, last_s2;
	logic signed [PROD_W-1:0]           prod_s2;
	logic signed [rdf_pkg::ACC_W-1:0]   acc_q;
	logic                               acc_full_q;

	logic              mem_we;
	logic              issue;
	logic              tap_first;
	logic              tap_end;
	logic              elem_end;
	logic              ord_end;
	logic signed [FW+1:0] tgt;
	logic [FW-1:0]     clamped;
	logic [ADDR_W-1:0] rd_addr;
	logic [ADDR_W-1:0] wr_addr;

	// constant tables: frame -> slot, and the tap list of each order
	for (genvar f = 0; f < FRAME_CNT; f++) begin : g_slot
		assign slot_tab[f] = SLOT_W'(f % FRAME_SLOTS);
	end

	for (genvar o = 0; o < rdf_pkg::DELTA_ORDER; o++) begin : g_ord
		assign tap_last[o] = rdf_pkg::TAP_W'(rdf_pkg::tap_count(o + 1) - 1);
		for (genvar i = 0; i < rdf_pkg::MAX_TAPS; i++) begin : g_tap
			assign off_tab[o][i]  = rdf_pkg::OFF_W'(rdf_pkg::tap_off(o + 1, i));
			assign coef_tab[o][i] = rdf_pkg::COEF_W'(
				rdf_pkg::win_num(o + 1, rdf_pkg::tap_off(o + 1, i)));
		end
	end

	assign issue     = (state_q == ST_RUN);
	assign tap_first = (tap_q == '0);
	assign tap_end   = (tap_q == tap_last[ord_q]);
	assign elem_end  = (elem_q == EIDX_W'(FEAT_SIZE - 1));
	assign ord_end   = (ord_q == rdf_pkg::ORD_IDX_W'(rdf_pkg::DELTA_ORDER - 1));

	// neighbor frame, clamped to 0..max_frame
	always_comb begin
		tgt = $signed({2'b00, frame_q}) + (FW+2)'(off_tab[ord_q][tap_q]);
		if (tgt < 0) begin
			clamped = '0;
		end else if (tgt > $signed({2'b00, maxf_q})) begin
			clamped = maxf_q;
		end else begin
			clamped = tgt[FW-1:0];
		end
	end

	assign rd_addr = ADDR_W'(slot_tab[clamped]) * ADDR_W'(FEAT_SIZE) + ADDR_W'(elem_q);
	assign wr_addr = ADDR_W'(slot_tab[cmd.frame]) * ADDR_W'(FEAT_SIZE) + ADDR_W'(cmd.element);

	always_comb begin
		cmd_pop = 1'b0;
		mem_we  = 1'b0;
		if (state_q == ST_IDLE && !cmd_empty) begin
			cmd_pop = 1'b1;
			mem_we  = (cmd.op == rdf_pkg::OP_WRITE);
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			store_mem[wr_addr] <= cmd.value;
		end
		rdata_s1 <= store_mem[rd_addr];
	end

	// sequencer: one tap read per cycle, then wait for the sum to be handed off
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ord_q   <= '0;
			elem_q  <= '0;
			tap_q   <= '0;
			frame_q <= '0;
			maxf_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (!cmd_empty && cmd.op == rdf_pkg::OP_COMPUTE) begin
						frame_q <= cmd.frame;
						maxf_q  <= cmd.max_frame;
						ord_q   <= '0;
						elem_q  <= '0;
						tap_q   <= '0;
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (tap_end) begin
						tap_q   <= '0;
						state_q <= ST_WAIT;
					end else begin
						tap_q <= tap_q + rdf_pkg::TAP_W'(1);
					end
				end
				ST_WAIT: begin
					if (!valid_s1 && !valid_s2 && !acc_full_q) begin
						if (elem_end) begin
							elem_q <= '0;
							if (ord_end) begin
								state_q <= ST_IDLE;
							end else begin
								ord_q   <= ord_q + rdf_pkg::ORD_IDX_W'(1);
								state_q <= ST_RUN;
							end
						end else begin
							elem_q  <= elem_q + EIDX_W'(1);
							state_q <= ST_RUN;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			first_s1   <= 1'b0;
			last_s1    <= 1'b0;
			valid_s2   <= 1'b0;
			first_s2   <= 1'b0;
			last_s2    <= 1'b0;
			acc_full_q <= 1'b0;
		end else begin
			valid_s1 <= issue;
			first_s1 <= tap_first;
			last_s1  <= tap_end;
			valid_s2 <= valid_s1;
			first_s2 <= first_s1;
			last_s2  <= last_s1;
			if (valid_s2 && last_s2) begin
				acc_full_q <= 1'b1;
			end else if (acc_full_q && div_ready) begin
				acc_full_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		coef_s1 <= coef_tab[ord_q][tap_q];
		prod_s2 <= rdata_s1 * coef_s1;
		if (valid_s2) begin
			acc_q <= (first_s2 ? '0 : acc_q) + rdf_pkg::ACC_W'(prod_s2);
		end
	end

	assign div_valid    = acc_full_q;
	assign div_req.acc  = acc_q;
	assign div_req.ord  = ord_q;
	assign div_req.elem = rdf_pkg::ELEM_IDX_W'(elem_q);
	assign div_req.last = ord_end && elem_end;

`ifndef NO_ASSERTIONS
	a_no_mac_while_held: assert property (@(posedge clk) disable iff (!arst_n)
		acc_full_q |-> !valid_s2)
		else $error("product arrived while a finished sum was held");

	a_no_issue_while_held: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) |-> !acc_full_q)
		else $error("tap issued while the previous sum is not handed off");

	a_held_from_last_tap: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(acc_full_q) |-> $past(valid_s2 && last_s2))
		else $error("sum marked done without its last tap");
`endif

endmodule

`default_nettype wire

>>> design/rdf_div.sv
`default_nettype none

module rdf_div (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire rdf_pkg::div_req_t req,
	input  wire logic              req_valid,
	output logic                   req_ready,
	output rdf_pkg::result_t       res,
	output logic                   res_valid,
	input  wire logic              res_ready
);

	localparam int AW = rdf_pkg::ACC_W;
	localparam int DW = rdf_pkg::DATA_W;
	localparam int NW = rdf_pkg::DEN_W;
	localparam int RX = rdf_pkg::DIV_RADIX;

	typedef enum logic [2:0] {ST_IDLE, ST_MAG, ST_PREP, ST_DIV, ST_OUT} state_t;

	state_t                        state_q;
	logic [rdf_pkg::STEP_W-1:0]    step_q;
	logic signed [AW-1:0]          acc_q;
	logic [AW-1:0]                 mag_q;
	logic                          neg_q;
	logic [NW-1:0]                 rem_q;
	logic [DW-1:0]                 quo_q;
	logic [DW-1:0]                 value_q;
	logic [rdf_pkg::ORD_IDX_W-1:0] ord_q;
	logic [rdf_pkg::ELEM_IDX_W-1:0] elem_q;
	logic                          last_q;

	logic [NW-1:0] den_c;
	logic [AW-1:0] half_c;
	logic [AW-1:0] thr_c;
	logic [AW-1:0] dsum;
	logic [NW:0]   trial;
	logic [NW-1:0] rem_nx;
	logic [RX-1:0] qbits;
	logic [DW-1:0] quo_nx;

	always_comb begin
		if (ord_q == '0) begin
			den_c  = NW'(rdf_pkg::den_of(1));
			half_c = AW'(rdf_pkg::den_of(1) / 2);
			thr_c  = neg_q ? AW'(rdf_pkg::thr_neg(1)) : AW'(rdf_pkg::thr_pos(1));
		end else begin
			den_c  = NW'(rdf_pkg::den_of(2));
			half_c = AW'(rdf_pkg::den_of(2) / 2);
			thr_c  = neg_q ? AW'(rdf_pkg::thr_neg(2)) : AW'(rdf_pkg::thr_pos(2));
		end
	end

	assign dsum = mag_q + half_c;

	// RX quotient bits per cycle, restoring
	always_comb begin
		rem_nx = rem_q;
		qbits  = '0;
		trial  = '0;
		for (int i = 0; i < RX; i++) begin
			trial = {rem_nx, quo_q[DW-1-i]};
			if (trial >= {1'b0, den_c}) begin
				rem_nx           = NW'(trial - {1'b0, den_c});
				qbits[RX-1-i]    = 1'b1;
			end else begin
				rem_nx = trial[NW-1:0];
			end
		end
		quo_nx = {quo_q[DW-RX-1:0], qbits};
	end

	assign req_ready = (state_q == ST_IDLE);
	assign res_valid = (state_q == ST_OUT);

	assign res.order       = rdf_pkg::ORDER_W'(ord_q) + rdf_pkg::ORDER_W'(1);
	assign res.element_res = rdf_pkg::ELEM_W'(elem_q);
	assign res.delta_value = value_q;
	assign res.last        = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						state_q <= ST_MAG;
					end
				end
				ST_MAG: begin
					state_q <= ST_PREP;
				end
				ST_PREP: begin
					step_q  <= '0;
					state_q <= (mag_q >= thr_c) ? ST_OUT : ST_DIV;
				end
				ST_DIV: begin
					step_q <= step_q + rdf_pkg::STEP_W'(1);
					if (step_q == rdf_pkg::STEP_W'(rdf_pkg::DIV_STEPS - 1)) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (res_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					acc_q  <= req.acc;
					ord_q  <= req.ord;
					elem_q <= req.elem;
					last_q <= req.last;
				end
			end
			ST_MAG: begin
				neg_q <= acc_q[AW-1];
				mag_q <= acc_q[AW-1] ? AW'(-acc_q) : AW'(acc_q);
			end
			ST_PREP: begin
				rem_q   <= dsum[DW +: NW];
				quo_q   <= dsum[DW-1:0];
				value_q <= neg_q ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
			end
			ST_DIV: begin
				rem_q <= rem_nx;
				quo_q <= quo_nx;
				if (step_q == rdf_pkg::STEP_W'(rdf_pkg::DIV_STEPS - 1)) begin
					value_q <= neg_q ? DW'(-quo_nx) : quo_nx;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire
